// ===== design/assert_macros.svh =====
// Assertion helpers used by the block's core RTL file.
// Every check samples on the rising edge of clk and is off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define ECPF_ASSERT(lbl, prop, msg) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	(prop)) else $error(msg);

// The expression must never be true at a sampled edge.
`define ECPF_ASSERT_NEVER(lbl, expr, msg) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ===== design/ecpf_pkg.sv =====
package ecpf_pkg;

	localparam int CRIB_MAX      = 32;
	localparam int POSITION_BITS = 16;

	localparam int LETTER_W   = 8;
	localparam int CRIB_IDX_W = 5;
	localparam int LEN_W      = 6;
	localparam int COUNT_W    = 16;
	localparam int CELL_IDX_W = (CRIB_MAX > 1) ? $clog2(CRIB_MAX) : 1;

	// Letter counter limit: the smaller of the position range and the counter width.
	localparam logic [COUNT_W-1:0] COUNT_LIMIT = (POSITION_BITS >= COUNT_W) ?
		{COUNT_W{1'b1}} : COUNT_W'((64'd1 << POSITION_BITS) - 64'd1);
	localparam logic [COUNT_W-1:0] TOTAL_LIMIT = {COUNT_W{1'b1}};

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_CRIB_LENGTH = '0;

	typedef enum logic {
		OP_CRIB   = 1'b0,
		OP_CIPHER = 1'b1
	} op_t;

	typedef struct packed {
		logic                rotate;
		logic                shift;
		logic                head;
		logic                in_len;
		logic                crib_we;
		logic [LETTER_W-1:0] letter;
	} cell_ctl_t;

	// Index of the last crib letter in use, with the length clamped to 1..CRIB_MAX.
	function automatic logic [CELL_IDX_W-1:0] last_index(input logic [LEN_W-1:0] len);
		logic [CELL_IDX_W-1:0] res;
		if (len == '0) begin
			res = '0;
		end else if (int'(len) > CRIB_MAX) begin
			res = CELL_IDX_W'(CRIB_MAX - 1);
		end else begin
			res = CELL_IDX_W'(len - LEN_W'(1));
		end
		return res;
	endfunction

endpackage

// ===== design/ecpf_cell.sv =====
module ecpf_cell (
	input  logic                         clk,
	input  ecpf_pkg::cell_ctl_t          ctl,
	input  logic [ecpf_pkg::LETTER_W-1:0] prev_letter,
	input  logic [ecpf_pkg::LETTER_W-1:0] next_letter,
	output logic [ecpf_pkg::LETTER_W-1:0] win_letter,
	output logic                         match
);

	logic [ecpf_pkg::LETTER_W-1:0] crib_q;
	logic [ecpf_pkg::LETTER_W-1:0] win_q;

	// The window letter either moves one place down the row on a new ciphertext
	// letter, or one place up the ring while the row is being realigned.
	always_ff @(posedge clk) begin
		if (ctl.crib_we) begin
			crib_q <= ctl.letter;
		end
		if (ctl.rotate) begin
			win_q <= prev_letter;
		end else if (ctl.shift) begin
			win_q <= ctl.head ? ctl.letter : next_letter;
		end
	end

	assign win_letter = win_q;
	assign match      = ctl.in_len && (crib_q == win_q);

endmodule

// ===== design/enigma_crib_position_filter_core.sv =====
// A ciphertext letter that completes a full window sets check_s1 when accepted and is checked
// against the cells in the next cycle; its result, if any, is registered in the output
// register once that register is free, which raises out_valid, and waits there while
// out_stall is high. Throughput: one item per cycle while results are taken; a crib_length
// write is followed by ring rotation in which no item is accepted.
// Reset (arst_n low, asynchronous): counters clear, crib_length returns to 1, no result is
// pending; crib letters are undefined until loaded.
`include "assert_macros.svh"

module enigma_crib_position_filter_core (
	input  logic                             clk,
	input  logic                             arst_n,

	// Configuration port.
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ecpf_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [ecpf_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [ecpf_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,

	// Input channel.
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             op,
	input  logic [ecpf_pkg::LETTER_W-1:0]    letter,
	input  logic [ecpf_pkg::CRIB_IDX_W-1:0]  crib_index,
	input  logic                             msg_start,

	// Output channel.
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [ecpf_pkg::COUNT_W-1:0]     position,
	output logic [ecpf_pkg::COUNT_W-1:0]     accepted_count
);

	// The cipher window lives in a ring of CRIB_MAX cells. Cell j sits next to crib
	// letter j and holds the ciphertext letter that lines up with it, so the newest
	// letter enters at the cell of the last crib letter in use and every other
	// letter moves one cell toward cell 0. The ring therefore depends on the crib
	// length: after a crib_length write the ring is rotated one cell per cycle until
	// its alignment (align_q) matches the new length. Cells beyond the crib length
	// keep the older letters, so no window content is lost by a length change.

	localparam int CW = ecpf_pkg::CELL_IDX_W;

	logic [ecpf_pkg::LEN_W-1:0]    crib_length_q;
	logic [CW-1:0]                 align_q;
	logic [CW-1:0]                 align_target;
	logic                          aligning;

	logic [ecpf_pkg::COUNT_W-1:0]  counter_q;
	logic [ecpf_pkg::COUNT_W-1:0]  total_q;
	logic [ecpf_pkg::COUNT_W-1:0]  cnt_base;
	logic [ecpf_pkg::COUNT_W-1:0]  cnt_next;
	logic [ecpf_pkg::COUNT_W-1:0]  len_ext;
	logic [ecpf_pkg::COUNT_W-1:0]  total_inc;

	logic                          check_s1;
	logic [ecpf_pkg::COUNT_W-1:0]  pos_s1;

	logic                          out_valid_q;
	logic [ecpf_pkg::COUNT_W-1:0]  position_q;
	logic [ecpf_pkg::COUNT_W-1:0]  count_q;

	logic                          in_xfer;
	logic                          is_cipher;
	logic                          shift;
	logic                          out_free;
	logic                          hit;
	logic                          result;
	logic                          cfg_wr;

	logic [ecpf_pkg::LETTER_W-1:0] win   [ecpf_pkg::CRIB_MAX];
	logic [ecpf_pkg::CRIB_MAX-1:0] match;

	// ------------------------------------------------------------------
	// Configuration register. pready is tied high, so the block never adds
	// wait states: every access completes in its setup and access phases.
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crib_length_q <= ecpf_pkg::LEN_W'(1);
		end else if (cfg_wr && (paddr[ecpf_pkg::APB_ADDR_W-1:2] == ecpf_pkg::REG_CRIB_LENGTH)) begin
			crib_length_q <= pwdata[ecpf_pkg::LEN_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[ecpf_pkg::APB_ADDR_W-1:2])
			ecpf_pkg::REG_CRIB_LENGTH: prdata = ecpf_pkg::APB_DATA_W'(crib_length_q);
			default: prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Ring alignment. Each rotation step moves every letter to the next cell
	// up, which lengthens the aligned crib by one, wrapping at CRIB_MAX.
	// ------------------------------------------------------------------
	assign align_target = ecpf_pkg::last_index(crib_length_q);
	assign aligning     = (align_q != align_target);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			align_q <= '0;
		end else if (aligning) begin
			if (align_q == CW'(ecpf_pkg::CRIB_MAX - 1)) begin
				align_q <= '0;
			end else begin
				align_q <= align_q + CW'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Input transfer and letter counting.
	// ------------------------------------------------------------------
	assign out_free  = !out_valid_q || !out_stall;
	// A pending check reads the window cells and crib letters, so nothing may
	// change them until its result has moved to the output register.
	assign in_stall  = aligning || (check_s1 && !out_free);
	assign in_xfer   = in_valid && !in_stall;
	assign is_cipher = (op == ecpf_pkg::OP_CIPHER);
	assign shift     = in_xfer && is_cipher;

	assign cnt_base = msg_start ? '0 : counter_q;
	assign cnt_next = (cnt_base < ecpf_pkg::COUNT_LIMIT) ?
		cnt_base + ecpf_pkg::COUNT_W'(1) : cnt_base;
	assign len_ext  = ecpf_pkg::COUNT_W'(align_q) + ecpf_pkg::COUNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
		end else if (shift) begin
			counter_q <= cnt_next;
		end
	end

	// Stage 1 marks a letter that completed a full window; its check runs
	// against the cells in the following cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_s1 <= 1'b0;
		end else if (in_xfer) begin
			check_s1 <= is_cipher && (cnt_next >= len_ext);
		end else if (out_free) begin
			check_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pos_s1 <= cnt_next - len_ext;
		end
	end

	// ------------------------------------------------------------------
	// Row of compare cells.
	// ------------------------------------------------------------------
	for (genvar j = 0; j < ecpf_pkg::CRIB_MAX; j++) begin : g_cell
		localparam int PREV = (j == 0) ? ecpf_pkg::CRIB_MAX - 1 : j - 1;
		localparam int NEXT = (j == ecpf_pkg::CRIB_MAX - 1) ? 0 : j + 1;

		ecpf_pkg::cell_ctl_t ctl;

		assign ctl.rotate  = aligning;
		assign ctl.shift   = shift;
		assign ctl.head    = (align_q == CW'(j));
		assign ctl.in_len  = (CW'(j) <= align_q);
		assign ctl.crib_we = in_xfer && !is_cipher && (32'(crib_index) == 32'(j));
		assign ctl.letter  = letter;

		ecpf_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.prev_letter (win[PREV]),
			.next_letter (win[NEXT]),
			.win_letter  (win[j]),
			.match       (match[j])
		);
	end

	// Any crib letter equal to the ciphertext letter under it rejects the window.
	assign hit    = |match;
	assign result = check_s1 && out_free && !hit;

	assign total_inc = (total_q < ecpf_pkg::TOTAL_LIMIT) ?
		total_q + ecpf_pkg::COUNT_W'(1) : total_q;

	// A new message clears the running count even when the last window of the
	// previous message retires in the same cycle; that result keeps its count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (shift && msg_start) begin
			total_q <= '0;
		end else if (result) begin
			total_q <= total_inc;
		end
	end

	// ------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= result;
		end
	end

	always_ff @(posedge clk) begin
		if (result) begin
			position_q <= pos_s1;
			count_q    <= total_inc;
		end
	end

	assign out_valid      = out_valid_q;
	assign position       = position_q;
	assign accepted_count = count_q;

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------
	`ECPF_ASSERT(a_clean_window_out, result |=> (out_valid && position == $past(pos_s1)), "result lost")
	`ECPF_ASSERT_NEVER(a_total_le_letters, total_q > counter_q, "accepted total exceeds letter count")
	`ECPF_ASSERT(a_msg_restart, (shift && msg_start) |=> (counter_q == 16'd1), "count not restarted")

endmodule

// ===== test/enigma_crib_position_filter_checker.sv =====
module enigma_crib_position_filter_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic                              pready,
	input  logic [ecpf_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [ecpf_pkg::APB_DATA_W-1:0]   pwdata,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              op,
	input  logic [ecpf_pkg::LETTER_W-1:0]     letter,
	input  logic [ecpf_pkg::CRIB_IDX_W-1:0]   crib_index,
	input  logic                              msg_start,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [ecpf_pkg::COUNT_W-1:0]      position,
	input  logic [ecpf_pkg::COUNT_W-1:0]      accepted_count,
	output int                                failures,
	output int                                outstanding
);

	localparam logic [ecpf_pkg::COUNT_W-1:0] LETTER_CAP =
		(ecpf_pkg::POSITION_BITS >= ecpf_pkg::COUNT_W) ? {ecpf_pkg::COUNT_W{1'b1}} :
		ecpf_pkg::COUNT_W'((64'd1 << ecpf_pkg::POSITION_BITS) - 64'd1);

	typedef struct packed {
		logic [ecpf_pkg::COUNT_W-1:0] position;
		logic [ecpf_pkg::COUNT_W-1:0] accepted_count;
	} alignment_t;

	logic [ecpf_pkg::LETTER_W-1:0] crib_letters [ecpf_pkg::CRIB_MAX];
	logic [ecpf_pkg::LETTER_W-1:0] cipher_tail [ecpf_pkg::CRIB_MAX];
	logic [ecpf_pkg::COUNT_W-1:0]  letters_seen;
	logic [ecpf_pkg::COUNT_W-1:0]  windows_passed;
	logic [ecpf_pkg::LEN_W-1:0]    crib_len;
	alignment_t                    open_alignments [$];
	int                            mismatch_tally;

	// Effective crib length: zero acts as one, oversize values act as the full crib.
	function automatic int used_length(input logic [ecpf_pkg::LEN_W-1:0] len);
		if (len == '0) return 1;
		if (int'(len) > ecpf_pkg::CRIB_MAX) return ecpf_pkg::CRIB_MAX;
		return int'(len);
	endfunction

	task automatic drag_crib(input ecpf_pkg::op_t kind,
			input logic [ecpf_pkg::LETTER_W-1:0] ch,
			input logic [ecpf_pkg::CRIB_IDX_W-1:0] slot, input logic first);
		int n;
		bit clash;
		alignment_t fresh;
		if (kind == ecpf_pkg::OP_CRIB) begin
			if (int'(slot) < ecpf_pkg::CRIB_MAX) crib_letters[slot] = ch;
			return;
		end
		if (first) begin
			letters_seen = '0;
			windows_passed = '0;
			foreach (cipher_tail[k]) cipher_tail[k] = '0;
		end
		for (int k = ecpf_pkg::CRIB_MAX - 1; k > 0; k--) cipher_tail[k] = cipher_tail[k-1];
		cipher_tail[0] = ch;
		if (letters_seen < LETTER_CAP) letters_seen++;
		n = used_length(crib_len);
		if (int'(letters_seen) < n) return;
		clash = 1'b0;
		for (int j = 0; j < n; j++) begin
			if (crib_letters[j] == cipher_tail[n-1-j]) clash = 1'b1;
		end
		if (clash) return;
		if (windows_passed != {ecpf_pkg::COUNT_W{1'b1}}) windows_passed++;
		fresh.position       = letters_seen - ecpf_pkg::COUNT_W'(n);
		fresh.accepted_count = windows_passed;
		open_alignments.insert(open_alignments.size(), fresh);
	endtask

	always @(posedge clk or negedge arst_n) begin
		alignment_t want;
		if (!arst_n) begin
			foreach (crib_letters[k]) crib_letters[k] = '0;
			foreach (cipher_tail[k]) cipher_tail[k] = '0;
			letters_seen = '0;
			windows_passed = '0;
			crib_len = ecpf_pkg::LEN_W'(1);
			open_alignments.delete();
			mismatch_tally = 0;
			failures <= 0;
			outstanding <= 0;
		end else begin
			// Compare first: a result leaving now never belongs to an item entering now.
			if (out_valid && !out_stall) begin
				if (open_alignments.size() == 0) begin
					$display("%0t: unexpected result, position %0d count %0d", $time,
						position, accepted_count);
					mismatch_tally++;
				end else begin
					want = open_alignments.pop_front();
					if (position !== want.position) begin
						$display("%0t: position expected %0d, actual %0d", $time,
							want.position, position);
						mismatch_tally++;
					end
					if (accepted_count !== want.accepted_count) begin
						$display("%0t: accepted_count expected %0d, actual %0d", $time,
							want.accepted_count, accepted_count);
						mismatch_tally++;
					end
				end
			end
			if (psel && penable && pwrite && pready &&
					paddr == {ecpf_pkg::REG_CRIB_LENGTH, 2'b00})
				crib_len = pwdata[ecpf_pkg::LEN_W-1:0];
			if (in_valid && !in_stall)
				drag_crib(ecpf_pkg::op_t'(op), letter, crib_index, msg_start);
			failures <= mismatch_tally;
			outstanding <= open_alignments.size();
		end
	end

endmodule

// ===== test/enigma_crib_position_filter_core_tb.sv =====
module enigma_crib_position_filter_core_tb;

	// Cycles without any transfer before the run is declared hung. The slowest
	// legitimate quiet stretch is a long random stall run or the ring rotation
	// after a length write, both far below this.
	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_ITEMS = 1150;
	// Letters of the closing message before its length change; more than a full crib.
	localparam int TAIL_LETTERS = 40;

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              psel;
	logic                              penable;
	logic                              pwrite;
	logic [ecpf_pkg::APB_ADDR_W-1:0]   paddr;
	logic [ecpf_pkg::APB_DATA_W-1:0]   pwdata;
	logic [ecpf_pkg::APB_DATA_W-1:0]   prdata;
	logic                              pready;
	logic                              in_valid;
	logic                              in_stall;
	logic                              op;
	logic [ecpf_pkg::LETTER_W-1:0]     letter;
	logic [ecpf_pkg::CRIB_IDX_W-1:0]   crib_index;
	logic                              msg_start;
	logic                              out_valid;
	logic                              out_stall;
	logic [ecpf_pkg::COUNT_W-1:0]      position;
	logic [ecpf_pkg::COUNT_W-1:0]      accepted_count;

	int                                failures;
	int                                outstanding;
	int                                in_gap_pct = 22;
	int                                out_stall_pct = 70;
	int                                items_sent = 0;
	int                                quiet_cycles = 0;
	int                                alphabet = 0;
	logic [ecpf_pkg::CRIB_MAX-1:0]     crib_loaded = '0;
	logic [ecpf_pkg::LEN_W-1:0]        opening_lengths [4] = '{6'd32, 6'd63, 6'd1, 6'd0};

	enigma_crib_position_filter_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.letter         (letter),
		.crib_index     (crib_index),
		.msg_start      (msg_start),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.position       (position),
		.accepted_count (accepted_count)
	);

	enigma_crib_position_filter_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.letter         (letter),
		.crib_index     (crib_index),
		.msg_start      (msg_start),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.position       (position),
		.accepted_count (accepted_count),
		.failures       (failures),
		.outstanding    (outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// The result side stalls at random, one fresh decision per cycle, so stalls
	// land on every phase of the block's pipeline.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < out_stall_pct);
	end

	// Watchdog: any transfer on either channel resets the count of quiet cycles.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Letters come from a narrow alphabet when we want many collisions, from the
	// capital letters for a realistic mix, or from the full byte range.
	function automatic logic [ecpf_pkg::LETTER_W-1:0] pick_letter();
		case (alphabet)
			0: begin
				return ecpf_pkg::LETTER_W'(65 + $urandom_range(25));
			end
			1: begin
				return ecpf_pkg::LETTER_W'($urandom_range(255));
			end
			default: begin
				return ecpf_pkg::LETTER_W'(65 + $urandom_range(3));
			end
		endcase
	endfunction

	// Offers one item, after an optional random gap, and returns at the clock edge
	// at which the transfer happens. Valid stays high for a following item, so no
	// signal is lowered and raised again in one time step.
	task automatic send_item(input ecpf_pkg::op_t kind,
			input logic [ecpf_pkg::LETTER_W-1:0] ch,
			input logic [ecpf_pkg::CRIB_IDX_W-1:0] slot, input logic first);
		while ($urandom_range(99) < in_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= kind;
		letter     <= ch;
		crib_index <= slot;
		msg_start  <= first;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		if (kind == ecpf_pkg::OP_CRIB) crib_loaded[slot] = 1'b1;
	endtask

	// Holds the sender off until every predicted alignment has been seen, then waits
	// on so that items that produce nothing have also retired.
	// The first edge makes the checker's count include the last transfer.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// A length write only happens with the block idle; the block then rotates its
	// ring and stalls the input, which the handshake absorbs.
	task automatic write_crib_length(input logic [ecpf_pkg::LEN_W-1:0] len);
		drain_results();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {ecpf_pkg::REG_CRIB_LENGTH, 2'b00};
		pwdata  <= ecpf_pkg::APB_DATA_W'(len);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Sets a crib length and makes sure every slot it reads holds a letter,
	// refreshing about a third of the slots already loaded.
	task automatic arm_crib(input logic [ecpf_pkg::LEN_W-1:0] len);
		int used;
		write_crib_length(len);
		used = (len == '0) ? 1 :
			((int'(len) > ecpf_pkg::CRIB_MAX) ? ecpf_pkg::CRIB_MAX : int'(len));
		for (int i = 0; i < used; i++) begin
			if (!crib_loaded[i] || $urandom_range(2) == 0)
				send_item(ecpf_pkg::OP_CRIB, pick_letter(), ecpf_pkg::CRIB_IDX_W'(i),
					1'($urandom_range(1)));
		end
	endtask

	initial begin
		logic [ecpf_pkg::LEN_W-1:0] len;
		int                         messages;
		int                         span;
		int                         used;
		int                         session;
		logic                       first;

		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		in_valid   <= 1'b0;
		op         <= ecpf_pkg::OP_CRIB;
		letter     <= '0;
		crib_index <= '0;
		msg_start  <= 1'b0;
		arst_n     <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with the reset length of one. A crib load carrying a message
		// start flag must leave the message alone; the first cipher letter after reset
		// starts a message without the flag.
		send_item(ecpf_pkg::OP_CRIB, 8'h41, 5'd0, 1'b1);
		send_item(ecpf_pkg::OP_CIPHER, 8'h41, 5'd0, 1'b0);
		send_item(ecpf_pkg::OP_CIPHER, 8'hFF, 5'h1F, 1'b0);
		send_item(ecpf_pkg::OP_CIPHER, 8'h00, 5'd0, 1'b0);
		send_item(ecpf_pkg::OP_CRIB, 8'h00, 5'd0, 1'b1);
		send_item(ecpf_pkg::OP_CIPHER, 8'h00, 5'd7, 1'b0);
		send_item(ecpf_pkg::OP_CIPHER, 8'h41, 5'd0, 1'b1);
		// A length of zero behaves as a length of one.
		write_crib_length(6'd0);
		send_item(ecpf_pkg::OP_CIPHER, 8'h00, 5'h10, 1'b1);
		send_item(ecpf_pkg::OP_CIPHER, 8'h80, 5'd0, 1'b0);
		// A three-letter crib: the first two letters of a message form only a partial
		// window, then windows both pass and collide.
		send_item(ecpf_pkg::OP_CRIB, 8'hFF, 5'd1, 1'b0);
		send_item(ecpf_pkg::OP_CRIB, 8'h55, 5'd2, 1'b0);
		write_crib_length(6'd3);
		send_item(ecpf_pkg::OP_CIPHER, 8'h01, 5'd0, 1'b1);
		send_item(ecpf_pkg::OP_CIPHER, 8'h02, 5'd0, 1'b0);
		send_item(ecpf_pkg::OP_CIPHER, 8'h03, 5'd0, 1'b0);
		send_item(ecpf_pkg::OP_CIPHER, 8'h55, 5'd0, 1'b0);
		send_item(ecpf_pkg::OP_CIPHER, 8'hAA, 5'd0, 1'b0);
		// A restart in the middle of a message cuts the window back to empty.
		send_item(ecpf_pkg::OP_CIPHER, 8'h7E, 5'd0, 1'b1);
		send_item(ecpf_pkg::OP_CIPHER, 8'h7F, 5'd0, 1'b0);

		// Random part: each session loads a crib, sets its length and streams a few
		// messages of random text through it, with stray crib loads and restarts mixed
		// in. The first sessions visit the length extremes, including out-of-range
		// codes. Idling moves from a slow receiver to a slow sender to none at all.
		items_sent = 0;
		session = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent < RANDOM_ITEMS / 3) begin
				in_gap_pct = 22;
				out_stall_pct = 70;
			end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
				in_gap_pct = 70;
				out_stall_pct = 22;
			end else begin
				in_gap_pct = 0;
				out_stall_pct = 0;
			end
			alphabet = $urandom_range(2);
			if (session < 4) begin
				len = opening_lengths[session];
			end else if ($urandom_range(9) == 0) begin
				len = ecpf_pkg::LEN_W'($urandom_range(63) == 0 ? 0 : $urandom_range(33, 63));
			end else begin
				len = ecpf_pkg::LEN_W'($urandom_range(1, 32));
			end
			arm_crib(len);
			used = (len == '0) ? 1 :
				((int'(len) > ecpf_pkg::CRIB_MAX) ? ecpf_pkg::CRIB_MAX : int'(len));
			messages = $urandom_range(1, 3);
			for (int m = 0; m < messages; m++) begin
				// Some messages are no longer than one full window.
				span = ($urandom_range(9) == 0) ? $urandom_range(1, used)
					: used + $urandom_range(40);
				for (int k = 0; k < span; k++) begin
					first = (k == 0) ? ($urandom_range(4) != 0) : ($urandom_range(39) == 0);
					if ($urandom_range(29) == 0)
						send_item(ecpf_pkg::OP_CRIB, pick_letter(),
							ecpf_pkg::CRIB_IDX_W'($urandom_range(31)),
							1'($urandom_range(1)));
					send_item(ecpf_pkg::OP_CIPHER, pick_letter(),
						ecpf_pkg::CRIB_IDX_W'($urandom_range(31)), first);
				end
			end
			session++;
		end

		// Closing part: with a one-letter crib that no text letter matches, every
		// window of a message passes. Then the full crib length is set in the middle of
		// that message, so the next letter already completes a full window, and a
		// fresh message later clears everything again.
		in_gap_pct = 0;
		out_stall_pct = 0;
		write_crib_length(6'd1);
		send_item(ecpf_pkg::OP_CRIB, 8'h00, 5'd0, 1'b0);
		for (int k = 0; k < TAIL_LETTERS; k++)
			send_item(ecpf_pkg::OP_CIPHER, ecpf_pkg::LETTER_W'($urandom_range(1, 255)), 5'd0,
				k == 0);
		alphabet = 1;
		write_crib_length(6'd32);
		for (int i = 0; i < ecpf_pkg::CRIB_MAX; i++) begin
			if (!crib_loaded[i])
				send_item(ecpf_pkg::OP_CRIB, pick_letter(), ecpf_pkg::CRIB_IDX_W'(i), 1'b0);
		end
		for (int k = 0; k < 80; k++)
			send_item(ecpf_pkg::OP_CIPHER, pick_letter(),
				ecpf_pkg::CRIB_IDX_W'($urandom_range(31)), k == 40);

		drain_results();
		repeat (4) @(posedge clk);
		if (failures == 0 && outstanding == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
